// ===== rtl/scv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes for the sequence container validator.
// No dependencies; imported by every module of the block.
package scv_pkg;

   // Largest accepted stream length, in words.
   localparam int MAX_WORDS = 1048576;
   // Word counts saturate here; a count this large can never complete.
   localparam int SAT_WORDS = MAX_WORDS + 1;
   localparam int SAT_W = $clog2(MAX_WORDS + 2);
   // Largest notes count whose 1 + 4 * notes does not exceed the saturation point.
   localparam int NOTES_LIM = SAT_WORDS / 4;

   // Depth of the queue between byte assembly and the layout walker.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // Walker phases.
   localparam logic [2:0] PH_COUNT  = 3'd0;
   localparam logic [2:0] PH_TABLE  = 3'd1;
   localparam logic [2:0] PH_HDR1   = 3'd2;
   localparam logic [2:0] PH_HDR2   = 3'd3;
   localparam logic [2:0] PH_NOTES  = 3'd4;
   localparam logic [2:0] PH_TRACKS = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   // Status codes reported with the last byte.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_TRUNC    = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_TRACK    = 3'd4;
   localparam logic [2:0] ST_TOO_LONG = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] word_out;
      logic        word_valid;
      logic        done_res;
      logic [2:0]  status;
   } rsp_type;

   // One entry between the front and the walker.
   typedef struct packed {
      logic [31:0] word;
      logic        word_valid;
      logic        last;
      logic        short_tail;   // stream ended mid-word
   } mid_type;

endpackage

// ===== rtl/scv_front.sv =====
`timescale 1ns / 1ps
// Byte assembly: packs bytes into big-endian words and queues word/last events.
// Depends on scv_pkg.
module scv_front
   import scv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_item,
   input  logic    q_full,
   output logic    q_push,
   output mid_type q_entry
);

   logic [1:0]  byte_phase_ff, byte_phase_in;
   logic [23:0] partial_ff, partial_in;
   logic        accept;
   logic        have_word;

   assign accept = push && !q_full;

   always_comb begin
      byte_phase_in = byte_phase_ff;
      partial_in    = partial_ff;
      have_word     = (byte_phase_ff == 2'd3);
      if (accept) begin
         if (have_word) begin
            byte_phase_in = 2'd0;
            partial_in    = 24'd0;
         end else begin
            byte_phase_in = byte_phase_ff + 2'd1;
            partial_in    = {partial_ff[15:0], req_item.data_byte};
         end
         if (req_item.last_byte) begin
            byte_phase_in = 2'd0;
            partial_in    = 24'd0;
         end
      end
   end

   assign q_push             = accept && (have_word || req_item.last_byte);
   assign q_entry.word       = have_word ? {partial_ff, req_item.data_byte} : 32'd0;
   assign q_entry.word_valid = have_word;
   assign q_entry.last       = req_item.last_byte;
   assign q_entry.short_tail = !have_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff <= 2'd0;
         partial_ff    <= 24'd0;
      end else begin
         byte_phase_ff <= byte_phase_in;
         partial_ff    <= partial_in;
      end
   end

endmodule

// ===== rtl/scv_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO between byte assembly and the layout walker.
// Depends on scv_pkg.
module scv_queue
   import scv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  mid_type wr_entry,
   input  logic    rd_en,
   output mid_type rd_entry,
   output logic    full,
   output logic    not_empty
);

   mid_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/scv_back.sv =====
`timescale 1ns / 1ps
// Layout walker: tracks the nested layout word by word, latches range errors,
// builds the final status and holds the output register. Depends on scv_pkg.
module scv_back
   import scv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  mid_type q_entry,
   output logic    q_pop,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_item
);

   localparam logic [31:0]        SAT_32   = 32'(SAT_WORDS);
   localparam logic [SAT_W-1:0]   SAT_V    = SAT_W'(SAT_WORDS);
   localparam logic [2*SAT_W-1:0] SAT_WIDE = (2 * SAT_W)'(SAT_WORDS);
   localparam logic [31:0]        NLIM_32  = 32'(NOTES_LIM);
   localparam logic [SAT_W-1:0]   MAX_V    = SAT_W'(MAX_WORDS);

   logic [SAT_W-1:0] word_total_ff, word_total_in;
   logic [2:0]       phase_ff, phase_in;
   logic [30:0]      groups_ff, groups_in;
   logic [31:0]      tracks_ff, tracks_in;
   logic [SAT_W-1:0] skip_ff, skip_in;
   logic [2:0]       first_err_ff, first_err_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          rsp_ff;

   logic [31:0]        w;
   logic [SAT_W-1:0]   w_sat;
   logic [SAT_W+1:0]   fac_wide;
   logic [SAT_W-1:0]   factor;
   logic [2*SAT_W-1:0] prod;
   logic [SAT_W-1:0]   track_cnt;
   logic [2:0]         status_v;

   assign w     = q_entry.word;
   assign w_sat = (w > SAT_32) ? SAT_V : w[SAT_W-1:0];

   // Track word count: tracks * (1 + 4 * notes), saturated. Large operands
   // saturate directly, so the product is used only when both operands are within their limits.
   assign fac_wide = {w[SAT_W-1:0], 2'b01};
   assign factor   = fac_wide[SAT_W-1:0];
   assign prod     = tracks_ff[SAT_W-1:0] * factor;

   always_comb begin
      if (tracks_ff == 32'd0) begin
         track_cnt = '0;
      end else if (tracks_ff > SAT_32 || w > NLIM_32 || prod > SAT_WIDE) begin
         track_cnt = SAT_V;
      end else begin
         track_cnt = prod[SAT_W-1:0];
      end
   end

   assign q_pop = q_valid && (!out_valid_ff || pop);

   always_comb begin
      word_total_in = word_total_ff;
      phase_in      = phase_ff;
      groups_in     = groups_ff;
      tracks_in     = tracks_ff;
      skip_in       = skip_ff;
      first_err_in  = first_err_ff;
      status_v      = ST_OK;
      if (q_pop && q_entry.word_valid) begin
         if (word_total_ff < SAT_V) begin
            word_total_in = word_total_ff + 1'b1;
         end
         if (first_err_ff == ST_OK) begin
            case (phase_ff)
               PH_COUNT: begin
                  if (w[31]) begin
                     first_err_in = ST_RANGE;
                  end else begin
                     groups_in = w[30:0];
                     skip_in   = w_sat;
                     phase_in  = (w == 32'd0) ? PH_DONE : PH_TABLE;
                  end
               end
               PH_TABLE: begin
                  skip_in = skip_ff - 1'b1;
                  if (skip_ff == SAT_W'(1)) begin
                     phase_in = PH_HDR1;
                  end
               end
               PH_HDR1: begin
                  tracks_in = w;
                  phase_in  = PH_HDR2;
               end
               PH_HDR2: begin
                  if (tracks_ff[31] || w[31]) begin
                     first_err_in = ST_RANGE;
                  end else begin
                     tracks_in = 32'(track_cnt);
                     skip_in   = w_sat;
                     if (w != 32'd0) begin
                        phase_in = PH_NOTES;
                     end else if (track_cnt != '0) begin
                        skip_in  = track_cnt;
                        phase_in = PH_TRACKS;
                     end else begin
                        groups_in = groups_ff - 1'b1;
                        phase_in  = (groups_ff == 31'd1) ? PH_DONE : PH_HDR1;
                     end
                  end
               end
               PH_NOTES: begin
                  skip_in = skip_ff - 1'b1;
                  if (skip_ff == SAT_W'(1)) begin
                     if (tracks_ff != 32'd0) begin
                        skip_in  = tracks_ff[SAT_W-1:0];
                        phase_in = PH_TRACKS;
                     end else begin
                        groups_in = groups_ff - 1'b1;
                        phase_in  = (groups_ff == 31'd1) ? PH_DONE : PH_HDR1;
                     end
                  end
               end
               PH_TRACKS: begin
                  skip_in = skip_ff - 1'b1;
                  if (skip_ff == SAT_W'(1)) begin
                     groups_in = groups_ff - 1'b1;
                     phase_in  = (groups_ff == 31'd1) ? PH_DONE : PH_HDR1;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // Final status: framing first, then length, then the walk.
      if (q_entry.short_tail || word_total_in == '0) begin
         status_v = ST_SHORT;
      end else if (word_total_in > MAX_V) begin
         status_v = ST_TOO_LONG;
      end else if (first_err_in != ST_OK) begin
         status_v = first_err_in;
      end else begin
         case (phase_in)
            PH_TABLE, PH_HDR1, PH_HDR2, PH_NOTES: status_v = ST_TRUNC;
            PH_TRACKS: status_v = ST_TRACK;
            PH_COUNT:  status_v = ST_SHORT;
            default:   status_v = ST_OK;
         endcase
      end

      // Last byte: the next stream starts clean.
      if (q_pop && q_entry.last) begin
         word_total_in = '0;
         phase_in      = PH_COUNT;
         groups_in     = '0;
         tracks_in     = '0;
         skip_in       = '0;
         first_err_in  = ST_OK;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff.word_out   <= w;
         rsp_ff.word_valid <= q_entry.word_valid;
         rsp_ff.done_res   <= q_entry.last;
         rsp_ff.status     <= q_entry.last ? status_v : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_total_ff <= '0;
         phase_ff      <= PH_COUNT;
         groups_ff     <= '0;
         tracks_ff     <= '0;
         skip_ff       <= '0;
         first_err_ff  <= ST_OK;
         out_valid_ff  <= 1'b0;
      end else begin
         word_total_ff <= word_total_in;
         phase_ff      <= phase_in;
         groups_ff     <= groups_in;
         tracks_ff     <= tracks_in;
         skip_ff       <= skip_in;
         first_err_ff  <= first_err_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

// ===== rtl/sequence_container_validator_top.sv =====
`timescale 1ns / 1ps
// Top level of the sequence container validator: byte assembly, queue, walker.
// Depends on scv_pkg, scv_front, scv_queue and scv_back.
//
// The block takes one byte per clock and assembles every four bytes into a
// big-endian word, which comes out as a result transaction. A transaction
// carrying last_byte also produces a result, with done_res set and the stream
// status: short or misaligned input first, then too long, then the first
// range error of the layout walk, then truncation of the group table,
// headers, notes or tracks. Bytes that neither complete a word nor close the
// stream produce no result. Sustained rate is one byte per cycle while full is
// low; the figure is set by the byte front, which handles one byte per clock,
// and by the walker, which retires one queued word per clock while the output
// register is free, including the saturated tracks * (1 + 4 * notes) product.
// A result passes through the queue and the output register. The 4-entry queue
// between front and walker and the output register let either side stall alone:
// full rises only when the queue fills behind a stalled consumer. All walker
// state returns to reset after the last byte, so streams follow back to back.
module sequence_container_validator_top
   import scv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // input transactions
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   // result transactions
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_item
);

   logic    q_full;
   logic    q_push;
   mid_type q_wr_entry;
   logic    q_pop;
   mid_type q_rd_entry;
   logic    q_not_empty;

   assign full = q_full;

   // Front: byte packing, one event per completed word or closing byte.
   scv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_item (req_item),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_wr_entry)
   );

   // Decoupling queue.
   scv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (q_push),
      .wr_entry  (q_wr_entry),
      .rd_en     (q_pop),
      .rd_entry  (q_rd_entry),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   // Back: layout walk, status and output register.
   scv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_not_empty),
      .q_entry  (q_rd_entry),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_item (rsp_item)
   );

`ifndef SYNTH
   // Every result carries a word or closes a stream.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.word_valid || rsp_item.done_res))
      else $error("result with neither word nor done");

   // Status is only nonzero on the closing result.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.done_res) |-> (rsp_item.status == ST_OK))
      else $error("status on a non-final result");

   // No word means a zero word field.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.word_valid) |-> (rsp_item.word_out == 32'd0))
      else $error("word field set without a word");

   // Reset leaves no result pending.
   assert property (@(posedge clock) (!reset && $past(reset)) |-> empty)
      else $error("result pending after reset");
`endif

endmodule

// ===== tb/tb_sequence_container_validator_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sequence_container_validator_top: directed and random byte streams.
// Depends on scv_pkg and the block's RTL; carries its own model of the layout walk.
module tb_sequence_container_validator_top;
   import scv_pkg::*;

   localparam logic [31:0] COUNT_LIMIT = 32'h7FFF_FFFF;
   // Stuck cycles (nothing accepted on either side) before the run is abandoned.
   localparam int STUCK_LIMIT = 3000;
   localparam int MAX_PRINTED = 50;

   typedef enum {POP_EAGER, POP_COIN, POP_SLOW, POP_BLOCKS} pop_style_e;
   typedef enum {SHAPE_CLEAN, SHAPE_CUT, SHAPE_BAD_COUNT, SHAPE_BAD_HEADER, SHAPE_NOISE}
      stream_shape_e;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_item = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_item;

   sequence_container_validator_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Model of the block: byte assembly and layout walk
   // ---------------------------------------------------------------
   logic [1:0]  asm_count;
   logic [23:0] asm_bytes;
   logic [20:0] words_seen;
   logic [2:0]  walk_phase;
   logic [30:0] groups_left;
   logic [31:0] pending_tracks;    // raw tracks word, then pending track word count
   logic [20:0] skip_count;
   logic [2:0]  latched_error;

   rsp_type results_due[$];
   int      error_count = 0;
   int      results_seen = 0;
   int      bytes_sent = 0;

   function automatic logic [20:0] clamp_words(input logic [63:0] v);
      return (v > 64'(SAT_WORDS)) ? 21'(SAT_WORDS) : v[20:0];
   endfunction

   function automatic void clear_stream_state();
      asm_count      = '0;
      asm_bytes      = '0;
      words_seen     = '0;
      walk_phase     = PH_COUNT;
      groups_left    = '0;
      pending_tracks = '0;
      skip_count     = '0;
      latched_error  = ST_OK;
   endfunction

   function automatic void close_group();
      groups_left = groups_left - 1'b1;
      walk_phase  = (groups_left == 0) ? PH_DONE : PH_HDR1;
   endfunction

   function automatic void start_tracks();
      if (pending_tracks != 0) begin
         skip_count = pending_tracks[20:0];
         walk_phase = PH_TRACKS;
      end else begin
         close_group();
      end
   endfunction

   function automatic void walk_layout(input logic [31:0] w);
      if (latched_error == ST_OK) begin
         case (walk_phase)
            PH_COUNT: begin
               if (w > COUNT_LIMIT) begin
                  latched_error = ST_RANGE;
               end else begin
                  groups_left = w[30:0];
                  skip_count  = clamp_words(64'(w));
                  walk_phase  = (skip_count != 0) ? PH_TABLE : PH_DONE;
               end
            end
            PH_TABLE: begin
               skip_count = skip_count - 1'b1;
               if (skip_count == 0) walk_phase = PH_HDR1;
            end
            PH_HDR1: begin
               pending_tracks = w;
               walk_phase     = PH_HDR2;
            end
            PH_HDR2: begin
               // both header counts are range checked only now
               if (pending_tracks > COUNT_LIMIT || w > COUNT_LIMIT) begin
                  latched_error = ST_RANGE;
               end else begin
                  pending_tracks = 32'(clamp_words(64'(pending_tracks) *
                                                   (64'd1 + 64'd4 * 64'(w))));
                  skip_count  = clamp_words(64'(w));
                  if (skip_count != 0) walk_phase = PH_NOTES;
                  else start_tracks();
               end
            end
            PH_NOTES: begin
               skip_count = skip_count - 1'b1;
               if (skip_count == 0) start_tracks();
            end
            PH_TRACKS: begin
               skip_count = skip_count - 1'b1;
               if (skip_count == 0) close_group();
            end
            default: ;
         endcase
      end
   endfunction

   function automatic logic [2:0] stream_status();
      if (asm_count != 0 || words_seen == 0) return ST_SHORT;
      if (words_seen > 21'(MAX_WORDS)) return ST_TOO_LONG;
      if (latched_error != ST_OK) return latched_error;
      case (walk_phase)
         PH_TABLE, PH_HDR1, PH_HDR2, PH_NOTES: return ST_TRUNC;
         PH_TRACKS: return ST_TRACK;
         PH_COUNT:  return ST_SHORT;
         default:   return ST_OK;
      endcase
   endfunction

   // One accepted byte: queue the result it causes, if any.
   function automatic void assemble_and_walk(input req_type r);
      rsp_type     due;
      logic [31:0] w;
      logic        got_word;
      w = '0;
      got_word = 1'b0;
      if (asm_count == 2'd3) begin
         w = {asm_bytes, r.data_byte};
         got_word = 1'b1;
         asm_count = '0;
         asm_bytes = '0;
         if (words_seen < 21'(SAT_WORDS)) words_seen = words_seen + 1'b1;
         walk_layout(w);
      end else begin
         asm_bytes = {asm_bytes[15:0], r.data_byte};
         asm_count = asm_count + 1'b1;
      end
      if (got_word || r.last_byte) begin
         due.word_out   = w;
         due.word_valid = got_word;
         due.done_res   = r.last_byte;
         due.status     = r.last_byte ? stream_status() : ST_OK;
         results_due.push_back(due);
         if (r.last_byte) clear_stream_state();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t ns: %s mismatch on result %0d: expected %h, got %h",
                  $time, what, results_seen, want, got);
   endtask

   // Both handshakes are sampled here, before the edge's updates land, so the
   // prediction and the check see the same values the block does.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_stream_state();
         results_due.delete();
      end else begin
         if (push && !full) assemble_and_walk(req_item);
         if (pop && !empty) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_item.word_out);
            end else begin
               want = results_due.pop_front();
               if (rsp_item.word_out !== want.word_out)
                  report_mismatch("word_out", want.word_out, rsp_item.word_out);
               if (rsp_item.word_valid !== want.word_valid)
                  report_mismatch("word_valid", 32'(want.word_valid), 32'(rsp_item.word_valid));
               if (rsp_item.done_res !== want.done_res)
                  report_mismatch("done_res", 32'(want.done_res), 32'(rsp_item.done_res));
               if (rsp_item.status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_item.status));
            end
            results_seen++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: pop follows a style, redrawn at random among eager, coin, slow and blocks
   // ---------------------------------------------------------------
   pop_style_e pop_style = POP_EAGER;
   int         style_left = 0;
   int         hold_left = 0;
   logic       take;
   logic       draining = 1'b0;

   always @(posedge clock) begin : receiver_pattern
      if (style_left == 0) begin
         pop_style  = pop_style_e'($urandom_range(0, 3));
         style_left = $urandom_range(16, 160);
      end
      style_left--;
      case (pop_style)
         POP_EAGER: take = 1'b1;
         POP_COIN:  take = 1'($urandom_range(0, 1));
         POP_SLOW:  take = ($urandom_range(0, 4) == 0);
         default: begin
            // long holds, to back the queue up until full rises
            if (hold_left != 0) begin
               hold_left--;
               take = 1'b0;
            end else begin
               take = 1'b1;
               if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(4, 24);
            end
         end
      endcase
      pop <= draining ? 1'b1 : take;
   end

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------
   int burst_left = 0;

   // One byte transaction; returns at the edge that accepts it.
   task automatic send_byte(input logic [7:0] value, input logic closes);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push     <= 1'b1;
      req_item <= '{data_byte: value, last_byte: closes};
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
   endtask

   // Hold the sender off until every queued result has come back.
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   function automatic void append_word(ref logic [7:0] s[$], input logic [31:0] w);
      s.push_back(w[31:24]);
      s.push_back(w[23:16]);
      s.push_back(w[15:8]);
      s.push_back(w[7:0]);
   endfunction

   // Last flag goes on the final byte; an empty stream becomes one stray byte.
   task automatic send_stream(input logic [7:0] s[$]);
      if (s.size() == 0) s.push_back(8'($urandom()));
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
   endtask

   task automatic send_words(input logic [31:0] ws[$], input int stray);
      logic [7:0] s[$];
      foreach (ws[i]) append_word(s, ws[i]);
      repeat (stray) s.push_back(8'($urandom()));
      send_stream(s);
   endtask

   // Well-formed container with random payload; bad_group >= 0 puts an
   // out-of-range count into that group's header.
   function automatic void build_layout(ref logic [7:0] s[$], input int groups,
                                        input int bad_group);
      int          t;
      int          n;
      logic [31:0] tw;
      logic [31:0] nw;
      append_word(s, 32'(groups));
      repeat (groups) append_word(s, $urandom());
      for (int g = 0; g < groups; g++) begin
         t  = $urandom_range(0, 2);
         n  = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(0, 1);
         tw = 32'(t);
         nw = 32'(n);
         if (g == bad_group) begin
            case ($urandom_range(0, 2))
               0: tw = 32'h8000_0000 | $urandom();
               1: nw = 32'h8000_0000 | $urandom();
               default: begin
                  tw = 32'h8000_0000 | $urandom();
                  nw = 32'h8000_0000 | $urandom();
               end
            endcase
         end
         append_word(s, tw);
         append_word(s, nw);
         repeat (n) append_word(s, $urandom());
         repeat (t * (1 + 4 * n)) append_word(s, $urandom());
      end
      // trailing words are legal
      repeat ($urandom_range(0, 2)) append_word(s, $urandom());
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_short_input();
      logic [31:0] ws[$];
      ws.delete();
      send_words(ws, 1);                  // lone byte
      send_words(ws, 3);                  // three bytes, no word
      ws = '{32'h0000_0000};
      send_words(ws, 2);                  // good layout, misaligned tail
   endtask

   task automatic test_group_count();
      logic [31:0] ws[$];
      ws = '{32'h0000_0000};
      send_words(ws, 0);                  // empty container
      ws = '{32'hFFFF_FFFF};
      send_words(ws, 0);                  // count range
      ws = '{32'h8000_0000, 32'h0000_0000};
      send_words(ws, 0);                  // just over the limit, word after it
      ws = '{32'h7FFF_FFFF};
      send_words(ws, 0);                  // largest count, table missing
      ws = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678};
      send_words(ws, 0);                  // trailing words
   endtask

   task automatic test_header_range();
      logic [31:0] ws[$];
      // bad tracks word, stream ends before notes: truncation, not range
      ws = '{32'd1, 32'hAAAA_5555, 32'h8000_0000};
      send_words(ws, 0);
      ws = '{32'd1, 32'h0, 32'd1, 32'hFFFF_FFFF};
      send_words(ws, 0);                  // notes out of range
      ws = '{32'd1, 32'h0, 32'd1, 32'hFFFF_FFFF, 32'h0};
      send_words(ws, 2);                  // range error hidden by misalignment
      ws = '{32'd2, 32'h0, 32'h0, 32'd0, 32'd0, 32'd0, 32'd0};
      send_words(ws, 0);                  // two empty groups
   endtask

   task automatic test_truncation();
      logic [31:0] ws[$];
      ws = '{32'd1, 32'h5A5A_A5A5, 32'd1, 32'd1, 32'hFFFF_0000,
             32'h0, 32'h1, 32'h2, 32'h3, 32'h4};
      send_words(ws, 0);                  // one track, one note: complete
      void'(ws.pop_back());
      send_words(ws, 0);                  // last track word missing
      ws = '{32'd1, 32'h0, 32'd1, 32'd1};
      send_words(ws, 0);                  // notes missing
      ws = '{32'd3, 32'h0, 32'h0};
      send_words(ws, 0);                  // group table short
   endtask

   task automatic test_large_counts();
      logic [31:0] ws[$];
      // huge product saturates; ends inside the track words
      ws = '{32'd1, 32'h0, 32'h7FFF_FFFF, 32'd0, 32'hDEAD_BEEF, 32'h0BAD_F00D};
      send_words(ws, 0);
      ws = '{32'd1, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hC001_D00D};
      send_words(ws, 0);                  // notes count saturates, truncated
      ws = '{32'd1, 32'h0, 32'd0, 32'h7FFF_FFFF};
      send_words(ws, 0);                  // zero tracks, huge notes
   endtask

   // Mostly well-formed containers, the rest cut, corrupted or plain noise.
   // A too-long stream needs over four million bytes and is not sent.
   task automatic test_random_streams(input int byte_goal);
      logic [7:0]    s[$];
      stream_shape_e shape;
      int            stop_at;
      int            pick;
      int            groups;
      int            keep;
      int            streams;
      stop_at = bytes_sent + byte_goal;
      streams = 0;
      while (bytes_sent < stop_at) begin
         s.delete();
         pick   = $urandom_range(0, 99);
         shape  = (pick < 55) ? SHAPE_CLEAN : (pick < 70) ? SHAPE_CUT :
                  (pick < 78) ? SHAPE_BAD_COUNT :
                  (pick < 88) ? SHAPE_BAD_HEADER : SHAPE_NOISE;
         groups = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
         case (shape)
            SHAPE_CLEAN: build_layout(s, groups, -1);
            SHAPE_CUT: begin
               build_layout(s, groups, -1);
               keep = $urandom_range(1, s.size() - 1);
               while (s.size() > keep) void'(s.pop_back());
            end
            SHAPE_BAD_COUNT: begin
               build_layout(s, groups, -1);
               s[0] = 8'h80 | 8'($urandom());
            end
            SHAPE_BAD_HEADER: begin
               if (groups == 0) groups = 1;
               build_layout(s, groups, $urandom_range(0, groups - 1));
            end
            default: begin
               // random bytes, with stream ends at random points
               keep = $urandom_range(1, 24);
               for (int i = 0; i < keep; i++)
                  send_byte(8'($urandom()), (i == keep - 1) || ($urandom_range(0, 5) == 0));
            end
         endcase
         if (shape != SHAPE_NOISE) send_stream(s);
         streams++;
         if (streams % 7 == 0) wait_drained();
      end
   endtask

   // ---------------------------------------------------------------
   // Run
   // ---------------------------------------------------------------
   initial begin : watchdog
      int stuck;
      stuck = 0;
      @(negedge reset);
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) stuck = 0;
         else stuck++;
      end
      $display("sequence_container_validator_top test failed");
      $finish;
   end

   initial begin : run
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_input();
      test_group_count();
      test_header_range();
      test_truncation();
      test_large_counts();
      wait_drained();
      test_random_streams(1050);
      wait_drained();
      // let any stray result show up with pop held high
      draining = 1'b1;
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("sequence_container_validator_top test passed");
      else
         $display("sequence_container_validator_top test failed");
      $finish;
   end

endmodule
